/* hdl/msd_pkg.sv */
// ----------------------------------------------------------------------------
// msd_pkg
// shared types, thresholds and helpers for the mode switch debouncer
// ----------------------------------------------------------------------------
package msd_pkg;

    // pulse width thresholds in microseconds, one per boundary between positions
    localparam logic [11:0] THR_POS1 = 12'd1231;
    localparam logic [11:0] THR_POS2 = 12'd1361;
    localparam logic [11:0] THR_POS3 = 12'd1491;
    localparam logic [11:0] THR_POS4 = 12'd1621;
    localparam logic [11:0] THR_POS5 = 12'd1750;

    // marker for "no position stored"
    localparam logic [2:0] POS_NONE = 3'd7;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd200;

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned APB_ADDR_W  = 6;
    localparam int unsigned APB_DATA_W  = 64;

    // register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_MODE_TABLE        = 3'd0,
        REG_SIMPLE_MASK       = 3'd1,
        REG_SUPER_SIMPLE_MASK = 3'd2,
        REG_AUX_OWNS_SIMPLE   = 3'd3,
        REG_DEBOUNCE_MS       = 3'd4
    } reg_idx_t;

    // simple mode levels
    localparam logic [1:0] SIMPLE_OFF   = 2'd0;
    localparam logic [1:0] SIMPLE_ON    = 2'd1;
    localparam logic [1:0] SIMPLE_SUPER = 2'd2;

    typedef struct packed {
        logic [47:0] mode_table;
        logic [5:0]  simple_mask;
        logic [5:0]  super_simple_mask;
        logic        aux_owns_simple;
        logic [15:0] debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic [11:0] pulse_us;
        logic [31:0] now_ms;
        logic        failsafe_active;
        logic        restart;
    } item_t;

    typedef struct packed {
        logic [2:0] position;
        logic       mode_valid;
        logic [7:0] mode_number;
        logic       simple_valid;
        logic [1:0] simple_level;
        logic       first_after_reset;
    } result_t;

    typedef struct packed {
        logic [2:0]  last_position;
        logic [2:0]  debounced_position;
        logic [31:0] last_edge_time;
    } state_t;

    function automatic logic [2:0] quantize(input logic [11:0] pulse);
        logic [2:0] pos;
        if (pulse < THR_POS1) begin
            pos = 3'd0;
        end else if (pulse < THR_POS2) begin
            pos = 3'd1;
        end else if (pulse < THR_POS3) begin
            pos = 3'd2;
        end else if (pulse < THR_POS4) begin
            pos = 3'd3;
        end else if (pulse < THR_POS5) begin
            pos = 3'd4;
        end else begin
            pos = 3'd5;
        end
        return pos;
    endfunction

endpackage

/* hdl/msd_apb_regs.sv */
// ----------------------------------------------------------------------------
// msd_apb_regs
// apb register file holding the mode table, masks, aux owner flag and debounce time
// ----------------------------------------------------------------------------
module msd_apb_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [msd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [msd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output msd_pkg::cfg_t                   cfg
);

    msd_pkg::cfg_t    cfg_reg;
    msd_pkg::cfg_t    cfg_next;
    msd_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = msd_pkg::reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                msd_pkg::REG_MODE_TABLE:        cfg_next.mode_table        = pwdata[47:0];
                msd_pkg::REG_SIMPLE_MASK:       cfg_next.simple_mask       = pwdata[5:0];
                msd_pkg::REG_SUPER_SIMPLE_MASK: cfg_next.super_simple_mask = pwdata[5:0];
                msd_pkg::REG_AUX_OWNS_SIMPLE:   cfg_next.aux_owns_simple   = pwdata[0];
                msd_pkg::REG_DEBOUNCE_MS:       cfg_next.debounce_ms       = pwdata[15:0];
                default: ;  // unmapped, write dropped
            endcase
        end
    end

    always_comb begin
        case (idx)
            msd_pkg::REG_MODE_TABLE:        prdata = {16'd0, cfg_reg.mode_table};
            msd_pkg::REG_SIMPLE_MASK:       prdata = {58'd0, cfg_reg.simple_mask};
            msd_pkg::REG_SUPER_SIMPLE_MASK: prdata = {58'd0, cfg_reg.super_simple_mask};
            msd_pkg::REG_AUX_OWNS_SIMPLE:   prdata = {63'd0, cfg_reg.aux_owns_simple};
            msd_pkg::REG_DEBOUNCE_MS:       prdata = {48'd0, cfg_reg.debounce_ms};
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_table        <= '0;
            cfg_reg.simple_mask       <= '0;
            cfg_reg.super_simple_mask <= '0;
            cfg_reg.aux_owns_simple   <= 1'b0;
            cfg_reg.debounce_ms       <= msd_pkg::DEBOUNCE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/msd_eval.sv */
// ----------------------------------------------------------------------------
// msd_eval
// quantize one sample, decide on a debounced change, compute next state
// ----------------------------------------------------------------------------
module msd_eval (
    input  msd_pkg::item_t   item,
    input  msd_pkg::state_t  state,
    input  msd_pkg::cfg_t    cfg,
    output msd_pkg::result_t res,
    output msd_pkg::state_t  state_next
);

    logic [2:0]  pos;
    logic [2:0]  last_eff;
    logic [2:0]  deb_eff;
    logic [31:0] edge_time;
    logic [31:0] elapsed;
    logic        accept;
    logic [7:0]  entry;

    always_comb begin
        pos      = msd_pkg::quantize(item.pulse_us);
        // restart forgets both stored positions before this sample
        last_eff = item.restart ? msd_pkg::POS_NONE : state.last_position;
        deb_eff  = item.restart ? msd_pkg::POS_NONE : state.debounced_position;

        edge_time = (last_eff != pos) ? item.now_ms : state.last_edge_time;
        elapsed   = item.now_ms - edge_time;
        accept    = (deb_eff != pos) && (elapsed > {16'd0, cfg.debounce_ms})
                    && !item.failsafe_active;

        case (pos)
            3'd0:    entry = cfg.mode_table[7:0];
            3'd1:    entry = cfg.mode_table[15:8];
            3'd2:    entry = cfg.mode_table[23:16];
            3'd3:    entry = cfg.mode_table[31:24];
            3'd4:    entry = cfg.mode_table[39:32];
            default: entry = cfg.mode_table[47:40];
        endcase

        res.position          = pos;
        res.mode_valid        = accept;
        res.mode_number       = accept ? entry : 8'd0;
        res.first_after_reset = accept && (deb_eff == msd_pkg::POS_NONE);
        res.simple_valid      = accept && !cfg.aux_owns_simple;
        if (!res.simple_valid) begin
            res.simple_level = msd_pkg::SIMPLE_OFF;
        end else if (cfg.super_simple_mask[pos]) begin
            res.simple_level = msd_pkg::SIMPLE_SUPER;
        end else if (cfg.simple_mask[pos]) begin
            res.simple_level = msd_pkg::SIMPLE_ON;
        end else begin
            res.simple_level = msd_pkg::SIMPLE_OFF;
        end

        state_next.last_position      = pos;
        state_next.debounced_position = accept ? pos : deb_eff;
        state_next.last_edge_time     = edge_time;
    end

endmodule

/* hdl/mode_switch_debouncer_top.sv */
// ----------------------------------------------------------------------------
// mode_switch_debouncer_top
// six-position mode switch debouncer with stream in/out and apb registers
// ----------------------------------------------------------------------------
//
//  channel   direction  width  contents
//  s_axis    in         48     pulse_us, now_ms, failsafe_active, restart
//  m_axis    out        16     position, mode_valid, mode_number, simple_valid,
//                              simple_level, first_after_reset
//  apb       in/out     64     mode_table, masks, aux_owns_simple, debounce_ms
//
//  one transfer per clock in each direction while m_axis is not stalled; a
//  sample goes from s_axis into the input register, then the result register
//  the throughput loop is the state update: compare, 32-bit subtract and
//  compare between the input register and the stored position/edge time
//  aresetn is synchronous, active low: positions go to none, edge time to 0
//  a stall on m_axis holds the result; s_axis keeps taking one more sample
//  into the input register, then tready drops until the result moves
// ----------------------------------------------------------------------------
module mode_switch_debouncer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [11:0] pulse_us, [43:12] now_ms, [44] failsafe_active, [45] restart,
    // [47:46] zero
    input  logic [msd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [2:0] position, [3] mode_valid, [11:4] mode_number, [12] simple_valid,
    // [14:13] simple_level, [15] first_after_reset
    output logic [msd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [msd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [msd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    msd_pkg::cfg_t    cfg;
    msd_pkg::item_t   item_reg;
    msd_pkg::item_t   item_next;
    logic             in_valid_reg;
    logic             in_valid_next;
    msd_pkg::state_t  state_reg;
    msd_pkg::state_t  state_next;
    msd_pkg::result_t ev;
    msd_pkg::result_t res_reg;
    msd_pkg::result_t res_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             s_xfer;
    logic             advance;
    logic             fire;

    msd_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msd_eval u_eval (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .res        (ev),
        .state_next (state_next)
    );

    // result register free now or emptied this cycle
    assign advance       = !m_valid_reg || m_axis_tready;
    // sample in the input register moves to the result register
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    // unpack input transfer, lowest field first
    always_comb begin
        item_next.pulse_us        = s_axis_tdata[11:0];
        item_next.now_ms          = s_axis_tdata[43:12];
        item_next.failsafe_active = s_axis_tdata[44];
        item_next.restart         = s_axis_tdata[45];
    end

    always_comb begin
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        res_next = fire ? ev : res_reg;
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg                 <= 1'b0;
            m_valid_reg                  <= 1'b0;
            state_reg.last_position      <= msd_pkg::POS_NONE;
            state_reg.debounced_position <= msd_pkg::POS_NONE;
            state_reg.last_edge_time     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg <= item_next;
        end
        res_reg <= res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {res_reg.first_after_reset, res_reg.simple_level,
                            res_reg.simple_valid, res_reg.mode_number,
                            res_reg.mode_valid, res_reg.position};

    // an accepted change becomes the debounced position
    a_deb_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ev.mode_valid) |=> (state_reg.debounced_position == $past(ev.position)))
        else $error("debounced position not updated after accepted change");

    // simple output only comes with a mode request
    a_simple_needs_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.simple_valid) |-> res_reg.mode_valid)
        else $error("simple_valid without mode_valid");

    // no request on a restart sample
    a_restart_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item_reg.restart) |-> !ev.mode_valid)
        else $error("mode request on restart sample");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // a held result is not overwritten
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |=> (m_valid_reg && $stable(res_reg)))
        else $error("stalled result changed");

endmodule

/* sim/tb_mode_switch_debouncer_top.sv */
// ----------------------------------------------------------------------------
// tb_mode_switch_debouncer_top
// self-checking bench for the six-position mode switch debouncer: a directed
// set of samples around thresholds, debounce limits, failsafe, restart and
// time wrap, then episodes of held, glitching and noisy switch traffic under
// four idle/stall patterns, each result checked against an in-bench predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mode_switch_debouncer_top;

    // register slots past the end of the list, writes there must be ignored
    localparam logic [2:0] REG_SPARE_A = 3'd5;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------
    logic                             aclk;
    logic                             aresetn;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [msd_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [msd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [msd_pkg::APB_ADDR_W-1:0]   paddr;
    logic [msd_pkg::APB_DATA_W-1:0]   pwdata;
    logic [msd_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    mode_switch_debouncer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 12 ns period
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // predictor state: own copy of registers and switch memory
    // ------------------------------------------------------------------
    msd_pkg::cfg_t sw_cfg = '{48'd0, 6'd0, 6'd0, 1'b0, msd_pkg::DEBOUNCE_RESET};
    logic [2:0]  sw_last_pos   = msd_pkg::POS_NONE;
    logic [2:0]  sw_stable_pos = msd_pkg::POS_NONE;
    logic [31:0] sw_edge_ms    = 32'd0;

    // predicted results in transfer order
    msd_pkg::result_t predicted_results[$];

    // traffic shaping, percent per cycle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // running time base for generated samples
    logic [31:0] stim_ms = 32'd1000;

    int n_sent       = 0;
    int n_checked    = 0;
    int n_mode_req   = 0;
    int n_first      = 0;
    int n_mismatches = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [2:0] position_of(input logic [11:0] pulse);
        logic [2:0] pos;
        pos = 3'd5;
        if (pulse < msd_pkg::THR_POS5) pos = 3'd4;
        if (pulse < msd_pkg::THR_POS4) pos = 3'd3;
        if (pulse < msd_pkg::THR_POS3) pos = 3'd2;
        if (pulse < msd_pkg::THR_POS2) pos = 3'd1;
        if (pulse < msd_pkg::THR_POS1) pos = 3'd0;
        return pos;
    endfunction

    function automatic msd_pkg::result_t predict_switch(input msd_pkg::item_t it);
        msd_pkg::result_t r;
        logic [2:0]       pos;
        logic [31:0]      elapsed;
        r = '0;
        // restart forgets both the last sample and the debounced position
        if (it.restart) begin
            sw_last_pos   = msd_pkg::POS_NONE;
            sw_stable_pos = msd_pkg::POS_NONE;
        end
        pos = position_of(it.pulse_us);
        if (sw_last_pos != pos) begin
            sw_edge_ms = it.now_ms;
        end
        elapsed = it.now_ms - sw_edge_ms;
        r.position = pos;
        if (sw_stable_pos != pos && elapsed > 32'(sw_cfg.debounce_ms)
                && !it.failsafe_active) begin
            r.mode_valid        = 1'b1;
            r.mode_number       = sw_cfg.mode_table[8*pos +: 8];
            r.first_after_reset = (sw_stable_pos == msd_pkg::POS_NONE);
            if (!sw_cfg.aux_owns_simple) begin
                r.simple_valid = 1'b1;
                // super simple takes priority over simple
                if (sw_cfg.super_simple_mask[pos]) begin
                    r.simple_level = msd_pkg::SIMPLE_SUPER;
                end else if (sw_cfg.simple_mask[pos]) begin
                    r.simple_level = msd_pkg::SIMPLE_ON;
                end else begin
                    r.simple_level = msd_pkg::SIMPLE_OFF;
                end
            end
            sw_stable_pos = pos;
        end
        sw_last_pos = pos;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // random pulse width inside one position band, band ends now and then
    function automatic logic [11:0] pulse_in_position(input int pos);
        int lo;
        int hi;
        case (pos)
            0: begin
                lo = 0;
                hi = int'(msd_pkg::THR_POS1) - 1;
            end
            1: begin
                lo = int'(msd_pkg::THR_POS1);
                hi = int'(msd_pkg::THR_POS2) - 1;
            end
            2: begin
                lo = int'(msd_pkg::THR_POS2);
                hi = int'(msd_pkg::THR_POS3) - 1;
            end
            3: begin
                lo = int'(msd_pkg::THR_POS3);
                hi = int'(msd_pkg::THR_POS4) - 1;
            end
            4: begin
                lo = int'(msd_pkg::THR_POS4);
                hi = int'(msd_pkg::THR_POS5) - 1;
            end
            default: begin
                lo = int'(msd_pkg::THR_POS5);
                hi = 4095;
            end
        endcase
        case ($urandom_range(7))
            0:       return 12'(lo);
            1:       return 12'(hi);
            default: return 12'($urandom_range(hi, lo));
        endcase
    endfunction

    // one sample over s_axis, predicted at the edge of its transfer
    task automatic send_sample(input msd_pkg::item_t it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.restart, it.failsafe_active, it.now_ms, it.pulse_us};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted_results.push_back(predict_switch(it));
        n_sent++;
    endtask

    task automatic send_fields(input logic [11:0] pulse, input logic [31:0] now,
                               input logic fs, input logic rst);
        msd_pkg::item_t it;
        it.pulse_us        = pulse;
        it.now_ms          = now;
        it.failsafe_active = fs;
        it.restart         = rst;
        send_sample(it);
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (predicted_results.size() != 0) @(posedge aclk);
        // allow the two-stage pipe to settle
        repeat (3) @(posedge aclk);
    endtask

    // apb write: setup then access, register takes the value at the access edge
    task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            msd_pkg::REG_MODE_TABLE:        sw_cfg.mode_table        = value[47:0];
            msd_pkg::REG_SIMPLE_MASK:       sw_cfg.simple_mask       = value[5:0];
            msd_pkg::REG_SUPER_SIMPLE_MASK: sw_cfg.super_simple_mask = value[5:0];
            msd_pkg::REG_AUX_OWNS_SIMPLE:   sw_cfg.aux_owns_simple   = value[0];
            msd_pkg::REG_DEBOUNCE_MS:       sw_cfg.debounce_ms       = value[15:0];
            default: ;
        endcase
        // bus goes idle so the next setup phase starts cleanly
        @(posedge aclk);
    endtask

    // all registers, only with the block idle
    task automatic set_config(input logic [63:0] table_v, input logic [63:0] smask,
                              input logic [63:0] ssmask, input logic [63:0] aux,
                              input logic [63:0] deb);
        wait_until_drained();
        write_register(msd_pkg::REG_MODE_TABLE, table_v);
        write_register(msd_pkg::REG_SIMPLE_MASK, smask);
        write_register(msd_pkg::REG_SUPER_SIMPLE_MASK, ssmask);
        write_register(msd_pkg::REG_AUX_OWNS_SIMPLE, aux);
        write_register(msd_pkg::REG_DEBOUNCE_MS, deb);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------
    // nothing written yet: table zero, masks clear, debounce at its reset value
    task automatic test_reset_values();
        send_fields(12'd1500, 32'd0, 1'b0, 1'b0);
        send_fields(12'd1500, 32'd201, 1'b0, 1'b0);
    endtask

    // every band edge once, extreme pulses included
    task automatic test_thresholds();
        set_config(64'h0000_A55A_3CC3_0FF0, 64'h15, 64'h03, 64'h0, 64'd200);
        send_fields(12'd0,    32'd5000, 1'b0, 1'b0);
        send_fields(12'd1230, 32'd5000, 1'b0, 1'b0);
        send_fields(12'd1231, 32'd5000, 1'b0, 1'b0);
        send_fields(12'd1360, 32'd5000, 1'b0, 1'b0);
        send_fields(12'd1361, 32'd5000, 1'b0, 1'b0);
        send_fields(12'd1490, 32'd5000, 1'b0, 1'b0);
        send_fields(12'd1491, 32'd5000, 1'b0, 1'b0);
        send_fields(12'd1620, 32'd5000, 1'b0, 1'b0);
        send_fields(12'd1621, 32'd5000, 1'b0, 1'b0);
        send_fields(12'd1749, 32'd5000, 1'b0, 1'b0);
        send_fields(12'd1750, 32'd5000, 1'b0, 1'b0);
        send_fields(12'd4095, 32'd5000, 1'b0, 1'b0);
    endtask

    // elapsed equal to the debounce time is not enough, one more ms is
    task automatic test_debounce_boundary();
        send_fields(12'd0, 32'd6000, 1'b0, 1'b0);
        send_fields(12'd0, 32'd6200, 1'b0, 1'b0);
        send_fields(12'd0, 32'd6201, 1'b0, 1'b0);
    endtask

    // failsafe blocks a change that would otherwise pass
    task automatic test_failsafe();
        send_fields(12'd4095, 32'd7000, 1'b0, 1'b0);
        send_fields(12'd4095, 32'd7300, 1'b1, 1'b0);
        send_fields(12'd4095, 32'd7301, 1'b0, 1'b0);
    endtask

    // restart makes the same position an edge again, then a first request
    task automatic test_restart();
        send_fields(12'd4095, 32'd7400, 1'b0, 1'b1);
        send_fields(12'd4095, 32'd7700, 1'b0, 1'b0);
    endtask

    // edge just before the time counter wraps
    task automatic test_time_wrap();
        send_fields(12'd1400, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_fields(12'd1400, 32'h0000_00C8, 1'b0, 1'b0);
        send_fields(12'd1400, 32'h0000_00C9, 1'b0, 1'b0);
    endtask

    // aux switch owns simple mode, zero debounce passes on any nonzero elapsed
    task automatic test_aux_owner();
        set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'h3F, 64'h3F, 64'h1, 64'd0);
        send_fields(12'd1700, 32'd9000, 1'b0, 1'b0);
        send_fields(12'd1700, 32'd9000, 1'b0, 1'b0);
        send_fields(12'd1700, 32'd9001, 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // random traffic: mostly held positions, plus glitches, limits and noise
    // ------------------------------------------------------------------
    task automatic run_traffic(input int n_items);
        int start;
        int kind;
        int count;
        int step_cap;
        int p;
        int i;
        logic [31:0] t0;
        start = n_sent;
        while (n_sent - start < n_items) begin
            kind     = $urandom_range(99);
            step_cap = int'(sw_cfg.debounce_ms) / 2 + 2;
            if ($urandom_range(99) < 3) stim_ms = $urandom();
            if (kind < 65) begin
                // switch moved and held, time advancing toward the debounce limit
                p     = $urandom_range(5);
                count = $urandom_range(7, 2);
                for (i = 0; i < count; i++) begin
                    stim_ms += $urandom_range(step_cap);
                    send_fields(pulse_in_position(p), stim_ms,
                                $urandom_range(99) < 6, $urandom_range(99) < 2);
                end
            end else if (kind < 80) begin
                // contact bounce: short hops between positions
                count = $urandom_range(4, 1);
                for (i = 0; i < count; i++) begin
                    stim_ms += $urandom_range(step_cap / 4 + 1);
                    send_fields(pulse_in_position($urandom_range(5)), stim_ms, 1'b0, 1'b0);
                end
            end else if (kind < 90) begin
                // forced edge, then exactly the debounce time, then one more
                p  = (int'(sw_last_pos) + 1 + $urandom_range(4)) % 6;
                t0 = stim_ms + 32'($urandom_range(step_cap));
                send_fields(pulse_in_position(p), t0, 1'b0, 1'b0);
                send_fields(pulse_in_position(p), t0 + 32'(sw_cfg.debounce_ms), 1'b0, 1'b0);
                stim_ms = t0 + 32'(sw_cfg.debounce_ms) + 32'd1;
                send_fields(pulse_in_position(p), stim_ms, $urandom_range(99) < 20, 1'b0);
            end else begin
                // anything the fields allow
                send_fields(12'($urandom_range(4095)), $urandom(),
                            1'($urandom_range(1)), $urandom_range(99) < 25);
            end
        end
    endtask

    task automatic test_stream_no_idle();
        set_config(rand64(), 64'($urandom_range(63)), 64'($urandom_range(63)),
                   64'h0, 64'd200);
        // writes to unused slots must leave the registers alone
        write_register(REG_SPARE_A, rand64());
        write_register(REG_SPARE_B, rand64());
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_traffic(400);
    endtask

    task automatic test_sender_gaps();
        set_config(64'hFFFF_FFFF_FFFF, 64'h3F, 64'h00, 64'h0, 64'd0);
        send_idle_pct  = 59;
        recv_stall_pct = 0;
        run_traffic(400);
    endtask

    task automatic test_receiver_stalls();
        set_config(rand64(), 64'($urandom_range(63)), 64'h3F, 64'h1, 64'd65535);
        send_idle_pct  = 0;
        recv_stall_pct = 59;
        run_traffic(400);
    endtask

    task automatic test_both_idle();
        set_config(64'h0, 64'($urandom_range(63)), 64'($urandom_range(63)),
                   64'h0, 64'($urandom_range(1000, 1)));
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        run_traffic(200);
        // reconfigure mid-stream, block idle in between
        set_config(rand64(), rand64(), rand64(), 64'($urandom_range(1)),
                   64'($urandom_range(400)));
        write_register(REG_SPARE_A, rand64());
        run_traffic(200);
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls on tready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // every m_axis transfer against the oldest prediction
    always @(posedge aclk) begin : switch_result_check
        msd_pkg::result_t got;
        msd_pkg::result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.position          = m_axis_tdata[2:0];
            got.mode_valid        = m_axis_tdata[3];
            got.mode_number       = m_axis_tdata[11:4];
            got.simple_valid      = m_axis_tdata[12];
            got.simple_level      = m_axis_tdata[14:13];
            got.first_after_reset = m_axis_tdata[15];
            if (predicted_results.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= MAX_REPORTS) begin
                    $display("unexpected result tdata=%h at %0t", m_axis_tdata, $realtime);
                end
            end else begin
                want = predicted_results.pop_front();
                n_checked++;
                if (got.mode_valid) n_mode_req++;
                if (got.first_after_reset) n_first++;
                if (got.position          !== want.position     ||
                    got.mode_valid        !== want.mode_valid   ||
                    got.mode_number       !== want.mode_number  ||
                    got.simple_valid      !== want.simple_valid ||
                    got.simple_level      !== want.simple_level ||
                    got.first_after_reset !== want.first_after_reset) begin
                    n_mismatches++;
                    if (n_mismatches <= MAX_REPORTS) begin
                        $display("result %0d: exp pos=%0d mv=%0d mode=%0d sv=%0d lvl=%0d first=%0d",
                                 n_checked, want.position, want.mode_valid,
                                 want.mode_number, want.simple_valid,
                                 want.simple_level, want.first_after_reset);
                        $display("result %0d: got pos=%0d mv=%0d mode=%0d sv=%0d lvl=%0d first=%0d",
                                 n_checked, got.position, got.mode_valid,
                                 got.mode_number, got.simple_valid,
                                 got.simple_level, got.first_after_reset);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b1;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_thresholds();
        test_debounce_boundary();
        test_failsafe();
        test_restart();
        test_time_wrap();
        test_aux_owner();

        test_stream_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        // drain, then wait on for anything stray
        wait_until_drained();
        repeat (10) @(posedge aclk);
        if (predicted_results.size() != 0) begin
            n_mismatches += predicted_results.size();
            $display("%0d predicted results never arrived", predicted_results.size());
        end

        $display("covered %0d samples, %0d results checked, %0d mode requests (%0d first)",
                 n_sent, n_checked, n_mode_req, n_first);
        $display("band edges, debounce limits, failsafe, restart, time wrap, four idle patterns");
        if (n_mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", predicted_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
